@@ sv/bmf_pkg.sv @@
// ----------------------------------------------------------------------------
// bmf_pkg: shared constants of the RGB box mean filter
// Register indexes, reset values and the fixed widths of the pixel fields.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int PIX_W        = 8;
    localparam int CHANNELS     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int ROW_W        = 9;
    localparam int HEIGHT_LIMIT = 512;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WIDTH = 2'd2;

    localparam logic [9:0] RESET_IMAGE_WIDTH  = 10'd512;
    localparam logic [9:0] RESET_IMAGE_HEIGHT = 10'd512;
    localparam logic [2:0] RESET_FILTER_WIDTH = 3'd3;

endpackage

@@ sv/rgb_box_mean_filter_core.sv @@
// ----------------------------------------------------------------------------
// rgb_box_mean_filter_core: streaming RGB box mean filter
// Stores incoming raster pixels in a line store and emits, for each position,
// the truncated per-channel mean of the border-clipped square window.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------
//  pixel   | pix_valid / pix_ready | red_in, green_in, blue_in, drain
//  result  | res_valid / res_ready | red_out, green_out, blue_out, end_of_frame
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A beat without a result stores the pixel, checks the window and returns to idle.
// A beat that releases a result scans the window of radius r:
// the window is read one pixel per cycle through the single line store read
// port, then the sums pass the eight cells of the divider chain.
// Reset clears all positions; the line store holds no reset value and is only
// read where the current frame has already written it.
// A result waiting in the output register does not block the next pixel beat;
// the next window is held before the divider until that register is free.

module rgb_box_mean_filter_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_RADIUS = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  logic [bmf_pkg::PIX_W-1:0]         red_in,
    input  logic [bmf_pkg::PIX_W-1:0]         green_in,
    input  logic [bmf_pkg::PIX_W-1:0]         blue_in,
    input  logic                              drain,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [bmf_pkg::PIX_W-1:0]         red_out,
    output logic [bmf_pkg::PIX_W-1:0]         green_out,
    output logic [bmf_pkg::PIX_W-1:0]         blue_out,
    output logic                              end_of_frame,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LINES   = 2 * MAX_RADIUS + 2;
    localparam int LINE_W  = $clog2(LINES);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = bmf_pkg::ROW_W;
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int SPAN_W  = $clog2(2 * MAX_RADIUS + 1);
    localparam int DEPTH   = LINES * MAX_WIDTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIN     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SUM_W   = $clog2(WIN * 255 + 1);
    localparam int CNT_W   = $clog2(WIN + 1);
    localparam int WCMP_W  = (COL_W + 1 > 10) ? COL_W + 1 : 10;
    localparam int RCMP_W  = (RAD_W > 2) ? RAD_W : 2;
    localparam int NCELLS  = bmf_pkg::PIX_W;
    localparam int CH      = bmf_pkg::CHANNELS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_TAIL   = 3'd3;
    localparam logic [2:0] ST_LAUNCH = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;

    // Configuration registers.
    logic [9:0] width_reg;
    logic [9:0] height_reg;
    logic [2:0] fw_reg;

    // Positions.
    logic [COL_W-1:0]  in_col_reg,  out_col_reg;
    logic [ROW_W-1:0]  in_row_reg,  out_row_reg;
    logic [LINE_W-1:0] in_line_reg, out_line_reg;
    logic              ahead_reg;

    logic [2:0]        state_reg;

    // Window scan.
    logic [SPAN_W-1:0] k_reg, j_reg;
    logic [LINE_W-1:0] slot_reg;
    logic              acc_en_reg;
    logic [CH-1:0][SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Line store.
    logic [23:0]       mem [DEPTH];
    logic [23:0]       rd_data_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    // Output register.
    logic              out_valid_reg;
    logic [CH-1:0][bmf_pkg::PIX_W-1:0] out_pix_reg;
    logic              out_eof_reg;

    // Effective geometry.
    logic [WCMP_W-1:0] width_ext;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [1:0]        rad_raw;
    logic [RAD_W-1:0]  rad;
    logic [SPAN_W-1:0] span_max;

    logic              pix_fire, cfg_fire, res_fire, launch;
    logic              win_ready;
    logic [ROW_W:0]    near_row;
    logic [COL_W:0]    near_col;
    logic [LINE_W:0]   slot_start;

    logic signed [ROW_W+1:0] row_s;
    logic signed [COL_W+1:0] col_s;
    logic              pos_ok;

    // Divider chain wiring.
    logic                                  st_v   [NCELLS+1];
    logic                                  st_eof [NCELLS+1];
    logic [CNT_W-1:0]                      st_div [NCELLS+1];
    logic [CH-1:0][SUM_W-1:0]              st_rem [NCELLS+1];
    logic [CH-1:0][bmf_pkg::PIX_W-1:0]     st_quo [NCELLS+1];

    // ------------------------------------------------------------------
    // Effective width, height and radius. Out-of-range values saturate.
    // ------------------------------------------------------------------
    assign width_ext = WCMP_W'(width_reg);

    always_comb
    begin
        priority if (width_reg == 10'd0)
        begin
            w_m1 = '0;
        end
        else if (width_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = COL_W'(width_ext - WCMP_W'(1));
        end
    end

    always_comb
    begin
        priority if (height_reg == 10'd0)
        begin
            h_m1 = '0;
        end
        else if (height_reg > 10'(bmf_pkg::HEIGHT_LIMIT))
        begin
            h_m1 = ROW_W'(bmf_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_m1 = ROW_W'(height_reg - 10'd1);
        end
    end

    assign rad_raw = fw_reg[2:1];

    always_comb
    begin
        if (RCMP_W'(rad_raw) > RCMP_W'(MAX_RADIUS))
        begin
            rad = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            rad = RAD_W'(rad_raw);
        end
    end

    assign span_max = SPAN_W'(rad) + SPAN_W'(rad);

    // ------------------------------------------------------------------
    // Handshakes. A configuration write wins over a pixel beat.
    // ------------------------------------------------------------------
    assign cfg_ready = (state_reg == ST_IDLE);
    assign pix_ready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign pix_fire  = pix_valid && pix_ready;
    assign res_fire  = out_valid_reg && res_ready;
    assign launch    = (state_reg == ST_LAUNCH) && !out_valid_reg;

    // ------------------------------------------------------------------
    // Is the whole clipped window of the next output already stored?
    // ------------------------------------------------------------------
    always_comb
    begin
        near_row = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(rad);
        if (near_row > (ROW_W+1)'(h_m1))
        begin
            near_row = (ROW_W+1)'(h_m1);
        end
        near_col = (COL_W+1)'(out_col_reg) + (COL_W+1)'(rad);
        if (near_col > (COL_W+1)'(w_m1))
        begin
            near_col = (COL_W+1)'(w_m1);
        end
        win_ready = ahead_reg
                 || ((ROW_W+1)'(in_row_reg) > near_row)
                 || (((ROW_W+1)'(in_row_reg) == near_row)
                     && ((COL_W+1)'(in_col_reg) > near_col));
    end

    // First line store slot of the window: radius rows above the output row.
    always_comb
    begin
        slot_start = (LINE_W+1)'(out_line_reg) + (LINE_W+1)'(LINES)
                   - (LINE_W+1)'(rad);
        if (slot_start >= (LINE_W+1)'(LINES))
        begin
            slot_start = slot_start - (LINE_W+1)'(LINES);
        end
    end

    // Image position of the window pixel being read.
    assign row_s  = signed'((ROW_W+2)'(out_row_reg)) + signed'((ROW_W+2)'(k_reg))
                  - signed'((ROW_W+2)'(rad));
    assign col_s  = signed'((COL_W+2)'(out_col_reg)) + signed'((COL_W+2)'(j_reg))
                  - signed'((COL_W+2)'(rad));
    assign pos_ok = (row_s >= 0) && (row_s <= signed'((ROW_W+2)'(h_m1)))
                 && (col_s >= 0) && (col_s <= signed'((COL_W+2)'(w_m1)));

    assign wr_addr = ADDR_W'(in_line_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg);
    assign rd_addr = ADDR_W'(slot_reg) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'(col_s[COL_W-1:0]);

    // ------------------------------------------------------------------
    // Line store: one write port, one registered read port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix_fire && !drain)
        begin
            mem[wr_addr] <= {red_in, green_in, blue_in};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Control: configuration, positions and the sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= bmf_pkg::RESET_IMAGE_WIDTH;
            height_reg    <= bmf_pkg::RESET_IMAGE_HEIGHT;
            fw_reg        <= bmf_pkg::RESET_FILTER_WIDTH;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_line_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_line_reg  <= '0;
            ahead_reg     <= 1'b0;
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            j_reg         <= '0;
            slot_reg      <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= (state_reg == ST_SCAN) && pos_ok;

            if (res_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if (st_v[NCELLS])
            begin
                out_valid_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        if (cfg_index == bmf_pkg::REG_IMAGE_WIDTH ||
                            cfg_index == bmf_pkg::REG_IMAGE_HEIGHT ||
                            cfg_index == bmf_pkg::REG_FILTER_WIDTH)
                        begin
                            // Any register write aborts the frame in progress.
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_line_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_line_reg <= '0;
                            ahead_reg    <= 1'b0;
                        end
                        if (cfg_index == bmf_pkg::REG_IMAGE_WIDTH)
                        begin
                            width_reg <= cfg_data;
                        end
                        if (cfg_index == bmf_pkg::REG_IMAGE_HEIGHT)
                        begin
                            height_reg <= cfg_data;
                        end
                        if (cfg_index == bmf_pkg::REG_FILTER_WIDTH)
                        begin
                            fw_reg <= cfg_data[2:0];
                        end
                    end
                    else if (pix_fire)
                    begin
                        if (!drain)
                        begin
                            if (in_col_reg == w_m1)
                            begin
                                in_col_reg  <= '0;
                                in_line_reg <= (in_line_reg == LINE_W'(LINES - 1))
                                             ? '0 : in_line_reg + LINE_W'(1);
                                if (in_row_reg == h_m1)
                                begin
                                    in_row_reg <= '0;
                                    ahead_reg  <= 1'b1;
                                end
                                else
                                begin
                                    in_row_reg <= in_row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + COL_W'(1);
                            end
                        end
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    k_reg    <= '0;
                    j_reg    <= '0;
                    slot_reg <= LINE_W'(slot_start);
                    state_reg <= win_ready ? ST_SCAN : ST_IDLE;
                end

                ST_SCAN:
                begin
                    if (j_reg == span_max)
                    begin
                        j_reg <= '0;
                        if (k_reg == span_max)
                        begin
                            state_reg <= ST_TAIL;
                        end
                        else
                        begin
                            k_reg    <= k_reg + SPAN_W'(1);
                            slot_reg <= (slot_reg == LINE_W'(LINES - 1))
                                      ? '0 : slot_reg + LINE_W'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + SPAN_W'(1);
                    end
                end

                ST_TAIL:
                begin
                    state_reg <= ST_LAUNCH;
                end

                ST_LAUNCH:
                begin
                    if (launch)
                    begin
                        if (out_col_reg == w_m1)
                        begin
                            out_col_reg  <= '0;
                            out_line_reg <= (out_line_reg == LINE_W'(LINES - 1))
                                          ? '0 : out_line_reg + LINE_W'(1);
                            if (out_row_reg == h_m1)
                            begin
                                out_row_reg <= '0;
                                ahead_reg   <= 1'b0;
                            end
                            else
                            begin
                                out_row_reg <= out_row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + COL_W'(1);
                        end
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (st_v[NCELLS])
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Window sums and pixel count. The read data is registered from the
    // address, so the in-image flag is registered alongside it.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CHECK)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            sum_reg[2] <= sum_reg[2] + SUM_W'(rd_data_reg[23:16]);
            sum_reg[1] <= sum_reg[1] + SUM_W'(rd_data_reg[15:8]);
            sum_reg[0] <= sum_reg[0] + SUM_W'(rd_data_reg[7:0]);
            cnt_reg    <= cnt_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: each cell settles one quotient bit, most significant
    // first, and passes its remainder on.
    // ------------------------------------------------------------------
    assign st_v[0]   = launch;
    assign st_eof[0] = (out_row_reg == h_m1) && (out_col_reg == w_m1);
    assign st_div[0] = cnt_reg;
    assign st_rem[0] = sum_reg;
    assign st_quo[0] = '0;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        bmf_div_cell #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W),
            .SHIFT (NCELLS - 1 - i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .valid       (st_v[i]),
            .eof         (st_eof[i]),
            .divisor     (st_div[i]),
            .rem         (st_rem[i]),
            .quo         (st_quo[i]),
            .valid_reg   (st_v[i+1]),
            .eof_reg     (st_eof[i+1]),
            .divisor_reg (st_div[i+1]),
            .rem_reg     (st_rem[i+1]),
            .quo_reg     (st_quo[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (st_v[NCELLS])
        begin
            out_pix_reg <= st_quo[NCELLS];
            out_eof_reg <= st_eof[NCELLS];
        end
    end

    assign res_valid    = out_valid_reg;
    assign red_out      = out_pix_reg[2];
    assign green_out    = out_pix_reg[1];
    assign blue_out     = out_pix_reg[0];
    assign end_of_frame = out_eof_reg;

endmodule

@@ sv/bmf_div_cell.sv @@
// ----------------------------------------------------------------------------
// bmf_div_cell: one cell of the divider chain
// Decides one quotient bit for all three channels and hands the partial
// remainder and quotient to the next cell on every clock.
// ----------------------------------------------------------------------------
module bmf_div_cell #(
    parameter int SUM_W = 14,
    parameter int CNT_W = 6,
    parameter int SHIFT = 0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       valid,
    input  logic                                       eof,
    input  logic [CNT_W-1:0]                           divisor,
    input  logic [bmf_pkg::CHANNELS-1:0][SUM_W-1:0]    rem,
    input  logic [bmf_pkg::CHANNELS-1:0][bmf_pkg::PIX_W-1:0] quo,
    output logic                                       valid_reg,
    output logic                                       eof_reg,
    output logic [CNT_W-1:0]                           divisor_reg,
    output logic [bmf_pkg::CHANNELS-1:0][SUM_W-1:0]    rem_reg,
    output logic [bmf_pkg::CHANNELS-1:0][bmf_pkg::PIX_W-1:0] quo_reg
);

    localparam int CMP_W = SUM_W + bmf_pkg::PIX_W + CNT_W;

    logic [CMP_W-1:0]                                 shifted;
    logic [bmf_pkg::CHANNELS-1:0][SUM_W-1:0]          rem_next;
    logic [bmf_pkg::CHANNELS-1:0][bmf_pkg::PIX_W-1:0] quo_next;

    // The divisor shifted into place; the remainder is always below twice it.
    assign shifted = CMP_W'(divisor) << SHIFT;

    always_comb
    begin
        for (int c = 0; c < bmf_pkg::CHANNELS; c++)
        begin
            if (CMP_W'(rem[c]) >= shifted)
            begin
                rem_next[c] = rem[c] - shifted[SUM_W-1:0];
                quo_next[c] = {quo[c][bmf_pkg::PIX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = rem[c];
                quo_next[c] = {quo[c][bmf_pkg::PIX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        eof_reg     <= eof;
        divisor_reg <= divisor;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

endmodule

@@ sv/bmf_checker.sv @@
// ----------------------------------------------------------------------------
// bmf_checker: port-level checks of the box mean filter
// Watches the top level's handshakes over time.
// ----------------------------------------------------------------------------
module bmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [bmf_pkg::PIX_W-1:0]     red_out,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // A waiting result is neither withdrawn nor changed.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(red_out))
        else $error("result beat dropped or changed while stalled");

    // The block works on one pixel beat at a time.
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("pixel accepted on two consecutive cycles");

    // A configuration write and a pixel beat never complete together.
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && pix_valid && pix_ready))
        else $error("configuration write and pixel beat in the same cycle");

    // A new result appears exactly when the block turns idle again.
    a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> cfg_ready)
        else $error("result raised while the block is still busy");

endmodule

bind rgb_box_mean_filter_core bmf_checker u_bmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .red_out   (red_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ bench/rgb_box_mean_filter_core_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_box_mean_filter_core_tb: self-checking bench for the RGB box mean filter
// Streams raster frames of several sizes and filter widths through the core,
// predicts every clipped window mean in the bench and compares each result
// beat field by field, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rgb_box_mean_filter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_RADIUS  = 3;
    localparam int LINES       = 2 * MAX_RADIUS + 2;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = 120;
    localparam logic [bmf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [bmf_pkg::PIX_W-1:0] red;
        logic [bmf_pkg::PIX_W-1:0] green;
        logic [bmf_pkg::PIX_W-1:0] blue;
        logic                      eof;
    } mean_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           pix_valid = 1'b0;
    logic                           pix_ready;
    logic [bmf_pkg::PIX_W-1:0]      red_in = '0;
    logic [bmf_pkg::PIX_W-1:0]      green_in = '0;
    logic [bmf_pkg::PIX_W-1:0]      blue_in = '0;
    logic                           drain = 1'b0;
    logic                           res_valid;
    logic                           res_ready = 1'b0;
    logic [bmf_pkg::PIX_W-1:0]      red_out;
    logic [bmf_pkg::PIX_W-1:0]      green_out;
    logic [bmf_pkg::PIX_W-1:0]      blue_out;
    logic                           end_of_frame;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rgb_box_mean_filter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .drain        (drain),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the filter: registers, raster positions and line store.
    logic [9:0]  shadow_width = bmf_pkg::RESET_IMAGE_WIDTH;
    logic [9:0]  shadow_height = bmf_pkg::RESET_IMAGE_HEIGHT;
    logic [2:0]  shadow_fw = bmf_pkg::RESET_FILTER_WIDTH;
    int unsigned in_col, in_row, out_col, out_row, in_line, out_line;
    bit          frame_ahead;
    logic [23:0] line_mem [LINES*MAX_WIDTH];
    // Pixels accepted whose means have not been released yet.
    int          pending_means;

    mean_t expected_means[$];
    int    fail_count;
    int    mismatch_count;
    int    beats_sent;

    // Sender burst shaping and receiver stall pattern, chosen per test.
    bit    sender_gaps;
    int    burst_left;
    int    stall_mode;
    int    stall_phase;

    function automatic int unsigned clip_width();
        int unsigned w;
        w = 32'(shadow_width);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned clip_height();
        int unsigned h;
        h = 32'(shadow_height);
        if (h == 0) h = 1;
        if (h > bmf_pkg::HEIGHT_LIMIT) h = bmf_pkg::HEIGHT_LIMIT;
        return h;
    endfunction

    function automatic int unsigned clip_radius();
        int unsigned r;
        r = 32'(shadow_fw) / 2;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        return r;
    endfunction

    // Advances the shadow filter by one accepted beat and queues the mean
    // that this beat releases, if any.
    task automatic predict_window_mean(input logic [7:0] r_px, input logic [7:0] g_px,
                                       input logic [7:0] b_px, input logic is_drain);
        int unsigned w, h, rad, nr, nc, cnt, slot;
        int unsigned sum_r, sum_g, sum_b;
        int          row, col;
        bit          ready;
        logic [23:0] px;
        mean_t       m;
        w = clip_width();
        h = clip_height();
        rad = clip_radius();
        if (!is_drain)
        begin
            line_mem[(in_line % LINES) * MAX_WIDTH + (in_col % MAX_WIDTH)] =
                {r_px, g_px, b_px};
            pending_means++;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_line = (in_line + 1) % LINES;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    frame_ahead = 1'b1;
                end
            end
        end
        if (frame_ahead)
            ready = 1'b1;
        else
        begin
            nr = out_row + rad;
            nc = out_col + rad;
            if (nr > h - 1) nr = h - 1;
            if (nc > w - 1) nc = w - 1;
            ready = (in_row > nr) || (in_row == nr && in_col > nc);
        end
        if (!ready)
            return;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt = 0;
        for (int k = 0; k <= 2 * rad; k++)
        begin
            row = int'(out_row) - int'(rad) + k;
            if (row < 0 || row >= int'(h))
                continue;
            slot = (out_line + LINES - rad + k) % LINES;
            for (int j = 0; j <= 2 * rad; j++)
            begin
                col = int'(out_col) - int'(rad) + j;
                if (col < 0 || col >= int'(w))
                    continue;
                px = line_mem[slot * MAX_WIDTH + (col % MAX_WIDTH)];
                sum_r += 32'(px[23:16]);
                sum_g += 32'(px[15:8]);
                sum_b += 32'(px[7:0]);
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        m.red = 8'(sum_r / cnt);
        m.green = 8'(sum_g / cnt);
        m.blue = 8'(sum_b / cnt);
        m.eof = (out_row == h - 1) && (out_col == w - 1);
        expected_means.push_back(m);
        pending_means--;
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_line = (out_line + 1) % LINES;
            out_row++;
            if (out_row >= h)
            begin
                out_row = 0;
                frame_ahead = 1'b0;
            end
        end
    endtask

    // Sends one beat on the pixel channel; called at a rising edge and
    // returns at the edge where the beat was accepted.
    task automatic send_beat(input logic [7:0] r_px, input logic [7:0] g_px,
                             input logic [7:0] b_px, input logic is_drain);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0) burst_left--;
        pix_valid <= 1'b1;
        red_in <= r_px;
        green_in <= g_px;
        blue_in <= b_px;
        drain <= is_drain;
        do @(posedge clk); while (!pix_ready);
        predict_window_mean(r_px, g_px, b_px, is_drain);
        beats_sent++;
    endtask

    task automatic send_pixel(input logic [7:0] r_px, input logic [7:0] g_px,
                              input logic [7:0] b_px);
        send_beat(r_px, g_px, b_px, 1'b0);
    endtask

    // Drain beats carry random colour bits, which the core must ignore.
    task automatic send_drain();
        send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    endtask

    task automatic flush_means();
        while (pending_means > 0)
            send_drain();
    endtask

    // Waits until every expected mean has arrived, then lets the core finish
    // any beat still in flight that releases no result.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmf_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        unique case (idx)
            bmf_pkg::REG_IMAGE_WIDTH:  shadow_width = value;
            bmf_pkg::REG_IMAGE_HEIGHT: shadow_height = value;
            bmf_pkg::REG_FILTER_WIDTH: shadow_fw = value[2:0];
            default:                   return;
        endcase
        // Any real register write aborts the frame in progress.
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        in_line = 0;
        out_line = 0;
        frame_ahead = 1'b0;
        pending_means = 0;
    endtask

    task automatic setup_frame(input logic [9:0] w, input logic [9:0] h,
                               input logic [9:0] fw);
        wait_idle();
        write_reg(bmf_pkg::REG_IMAGE_WIDTH, w);
        write_reg(bmf_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(bmf_pkg::REG_FILTER_WIDTH, fw);
    endtask

    // One frame of random pixels; drains are sprinkled in at the given rate
    // in percent.
    task automatic stream_frame(input int drain_pct);
        int n;
        n = int'(clip_width() * clip_height());
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < drain_pct)
                send_drain();
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // With the reset registers the first mean would need over five hundred
    // pixels, so a short partial frame is sent and then aborted by a write.
    task automatic test_reset_registers();
        stall_mode = 0;
        sender_gaps = 1'b0;
        for (int i = 0; i < 12; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        send_drain();
        wait_idle();
    endtask

    task automatic test_border_extremes();
        stall_mode = 1;
        // Width and height of zero act as one: every pixel is its own mean.
        setup_frame(10'd0, 10'd0, 10'd0);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hA5, 8'h5A, 8'h0F);
        // A 3x3 frame of full white under the widest filter, whose window
        // is clipped to the whole frame, followed by full black, both drained.
        setup_frame(10'd3, 10'd3, 10'd7);
        for (int i = 0; i < 9; i++)
            send_pixel(8'hFF, 8'hFF, 8'hFF);
        flush_means();
        for (int i = 0; i < 9; i++)
            send_pixel(8'h00, 8'h00, 8'h00);
        flush_means();
        // A drain with nothing pending releases nothing.
        send_drain();
        send_drain();
    endtask

    task automatic test_even_width_and_ignored_index();
        stall_mode = 2;
        sender_gaps = 1'b1;
        setup_frame(10'd4, 10'd3, 10'd2);
        stream_frame(0);
        flush_means();
        // An index past the register list must not abort anything.
        wait_idle();
        write_reg(REG_UNUSED, 10'h3FF);
        stream_frame(10);
        flush_means();
    endtask

    // Width above the store size acts as the maximum; the start of one row
    // is sent and the frame is then cut short by the next write.
    task automatic test_oversize_width();
        stall_mode = 0;
        sender_gaps = 1'b0;
        setup_frame(10'h3FF, 10'd1, 10'd6);
        for (int i = 0; i < 24; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        // Oversize height: a partial frame aborted by the next write.
        setup_frame(10'd2, 10'h3FF, 10'd1);
        for (int i = 0; i < 6; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Frames follow each other without drains, so the next frame starts while
    // means of the previous one are still owed.
    task automatic test_back_to_back_frames();
        stall_mode = 1;
        sender_gaps = 1'b1;
        setup_frame(10'd5, 10'd4, 10'd5);
        stream_frame(0);
        stream_frame(0);
        stream_frame(5);
        flush_means();
    endtask

    task automatic test_random_frames();
        int start;
        start = beats_sent;
        while (beats_sent - start < 420)
        begin
            stall_mode = $urandom_range(0, 2);
            sender_gaps = 1'($urandom_range(0, 1));
            setup_frame(10'($urandom_range(1, 14)), 10'($urandom_range(1, 8)),
                        10'($urandom_range(0, 7)));
            repeat ($urandom_range(1, 3))
                stream_frame($urandom_range(0, 15));
            // Now and then the frame is cut short by the next setup instead.
            if ($urandom_range(0, 4) == 0)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            else
                flush_means();
        end
    endtask

    // Receiver: stalls per mode, then checks every accepted result beat
    // against the oldest expected mean.
    always @(posedge clk)
    begin
        mean_t exp_m;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display("unexpected result beat r=%0d g=%0d b=%0d eof=%0b",
                                 red_out, green_out, blue_out, end_of_frame);
                    mismatch_count++;
                end
                else
                begin
                    exp_m = expected_means.pop_front();
                    if (exp_m.red !== red_out || exp_m.green !== green_out ||
                        exp_m.blue !== blue_out || exp_m.eof !== end_of_frame)
                    begin
                        fail_count++;
                        if (mismatch_count < 10)
                            $display("mean mismatch: expected r=%0d g=%0d b=%0d eof=%0b,",
                                     exp_m.red, exp_m.green, exp_m.blue, exp_m.eof,
                                     " got r=%0d g=%0d b=%0d eof=%0b",
                                     red_out, green_out, blue_out, end_of_frame);
                        mismatch_count++;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            unique case (stall_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= ($urandom_range(0, 2) != 0);
                default: res_ready <= (stall_phase % 16) < 9;
            endcase
        end
    end

    // Watchdog: counts cycles with no beat accepted on any channel.
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_registers();
        test_border_extremes();
        test_even_width_and_ignored_index();
        test_oversize_width();
        test_back_to_back_frames();
        test_random_frames();
        wait_idle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
